@@ rtl/kpef_pkg.sv @@
// package for the key press edge fifo unit
// holds default sizes, item kinds and the ignored mouse button codes
package kpef_pkg;

  localparam int KEY_COUNT_DEF   = 256;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int CODE_W = 8;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CHECK  = 1'b1
  } kind_t;

  localparam logic [CODE_W-1:0] MOUSE_LEFT   = 8'd1;
  localparam logic [CODE_W-1:0] MOUSE_RIGHT  = 8'd2;
  localparam logic [CODE_W-1:0] MOUSE_MIDDLE = 8'd4;

endpackage

@@ rtl/kpef_ram.sv @@
// generic single write port ram with registered read, read returns old data
// no dependencies
module kpef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/key_press_edge_fifo_unit.sv @@
// key press edge detector with a key code fifo, top level
// depends on kpef_pkg and kpef_ram
//
// usage:
//   input channel (in_valid/in_ready) carries one word per item: a key level
//   sample (in_kind = sample) or a queue check (in_kind = check)
//   result channel (out_valid/out_ready) returns exactly one word per item:
//   key_waiting/key_out for a check, enqueued/dropped for a sample
//   a word is taken into an input register, processed there and written into the
//   result register, which raises out_valid; one word per cycle is sustained
//   while out_ready is high; the pressed flag of the sampled key and the head
//   of the queue are read from rams in advance, each with a bypass for a write
//   to the slot being read
//   when out_ready is low the result register holds and the input register
//   keeps one more word; in_ready drops only while both are full and stalled,
//   or during the clearing pass; reset clears the queue pointers and both
//   valid flags, then a clearing pass zeroes all KEY_COUNT pressed flags with
//   in_ready low; queue ram contents are not cleared and need no clearing pass
module key_press_edge_fifo_unit
  import kpef_pkg::*;
#(
  parameter int KEY_COUNT   = KEY_COUNT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [CODE_W-1:0] in_key_code,
  input  logic              in_key_down,
  input  logic              in_in_focus,
  input  logic              in_remove_key,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_key_waiting,
  output logic [CODE_W-1:0] out_key_out,
  output logic              out_enqueued,
  output logic              out_dropped
);

  localparam int KEY_W = $clog2(KEY_COUNT);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  logic              s1_v_r;
  kind_t             s1_kind_r;
  logic [CODE_W-1:0] s1_code_r;
  logic              s1_down_r;
  logic              s1_focus_r;
  logic              s1_remove_r;

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              byp_v_r;
  logic [CODE_W-1:0] byp_data_r;

  logic              clr_r;
  logic [KEY_W-1:0]  clr_idx_r;
  logic              pbyp_v_r;
  logic              pbyp_data_r;

  logic              out_v_r;
  logic              out_waiting_r, out_waiting_nxt;
  logic [CODE_W-1:0] out_key_r, out_key_nxt;
  logic              out_enq_r, out_enq_nxt;
  logic              out_drop_r, out_drop_nxt;

  logic              advance;
  logic              code_ok;
  logic [KEY_W-1:0]  key_idx;
  logic              flag_wr;
  logic              press_we;
  logic [KEY_W-1:0]  press_waddr;
  logic              press_wdata;
  logic [KEY_W-1:0]  press_raddr;
  logic              press_q;
  logic              pressed;
  logic              new_press;
  logic              q_full;
  logic              do_enq;
  logic              do_pop;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail_ptr;
  logic [SUM_W-1:0]  rd_inc;
  logic [CODE_W-1:0] ram_q;
  logic [CODE_W-1:0] head;

  assign advance  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !clr_r && (!s1_v_r || advance);
  assign key_idx  = s1_code_r[KEY_W-1:0];

  // pressed flag ram port: clearing pass after reset, else the sampled key
  assign flag_wr     = advance && code_ok;
  assign press_we    = clr_r || flag_wr;
  assign press_waddr = clr_r ? clr_idx_r : key_idx;
  assign press_wdata = clr_r ? 1'b0 : s1_down_r;
  assign press_raddr = (in_valid && in_ready) ? in_key_code[KEY_W-1:0] : key_idx;
  assign pressed     = pbyp_v_r ? pbyp_data_r : press_q;

  always_comb begin
    code_ok = (s1_kind_r == KIND_SAMPLE)
              && !(s1_code_r inside {MOUSE_LEFT, MOUSE_RIGHT, MOUSE_MIDDLE})
              && (int'(s1_code_r) < KEY_COUNT);
    new_press = code_ok && s1_down_r && !pressed;
    q_full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
    do_enq    = new_press && s1_focus_r && !q_full;
    head      = byp_v_r ? byp_data_r : ram_q;

    out_waiting_nxt = (s1_kind_r == KIND_CHECK) && (cnt_r != '0);
    out_key_nxt     = out_waiting_nxt ? head : '0;
    out_enq_nxt     = do_enq;
    out_drop_nxt    = new_press && s1_focus_r && q_full;
    do_pop          = out_waiting_nxt && s1_remove_r;

    tail_sum = SUM_W'(rd_ptr_r) + SUM_W'(cnt_r);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_ptr = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail_ptr = PTR_W'(tail_sum);
    end
    rd_inc = SUM_W'(rd_ptr_r) + SUM_W'(1);
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (advance) begin
      if (do_enq) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (do_pop) begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (rd_inc == SUM_W'(QUEUE_DEPTH)) begin
          rd_ptr_nxt = '0;
        end else begin
          rd_ptr_nxt = PTR_W'(rd_inc);
        end
      end
    end
  end

  kpef_ram #(
    .WIDTH (CODE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (advance && do_enq),
    .wr_addr (tail_ptr),
    .wr_data (s1_code_r),
    .rd_addr (rd_ptr_nxt),
    .rd_data (ram_q)
  );

  kpef_ram #(
    .WIDTH (1),
    .DEPTH (KEY_COUNT)
  ) u_press_ram (
    .clk     (clk),
    .wr_en   (press_we),
    .wr_addr (press_waddr),
    .wr_data (press_wdata),
    .rd_addr (press_raddr),
    .rd_data (press_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      byp_v_r   <= 1'b0;
      pbyp_v_r  <= 1'b0;
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      byp_v_r  <= advance && do_enq && (tail_ptr == rd_ptr_nxt);
      pbyp_v_r <= flag_wr && (key_idx == press_raddr);
      if (clr_r) begin
        if (clr_idx_r == KEY_W'(KEY_COUNT - 1)) begin
          clr_r <= 1'b0;
        end else begin
          clr_idx_r <= clr_idx_r + KEY_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r   <= kind_t'(in_kind);
      s1_code_r   <= in_key_code;
      s1_down_r   <= in_key_down;
      s1_focus_r  <= in_in_focus;
      s1_remove_r <= in_remove_key;
    end
    if (advance) begin
      out_waiting_r <= out_waiting_nxt;
      out_key_r     <= out_key_nxt;
      out_enq_r     <= out_enq_nxt;
      out_drop_r    <= out_drop_nxt;
    end
    byp_data_r  <= s1_code_r;
    pbyp_data_r <= s1_down_r;
  end

  assign out_valid       = out_v_r;
  assign out_key_waiting = out_waiting_r;
  assign out_key_out     = out_key_r;
  assign out_enqueued    = out_enq_r;
  assign out_dropped     = out_drop_r;

endmodule

@@ rtl/kpef_checker.sv @@
// port level checker for key_press_edge_fifo_unit, bound to the top level
// depends on kpef_pkg
module kpef_checker
  import kpef_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_key_waiting,
  input logic [CODE_W-1:0] out_key_out,
  input logic              out_enqueued,
  input logic              out_dropped
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_waiting)
      && $stable(out_key_out) && $stable(out_enqueued) && $stable(out_dropped))
    else $error("result word changed while stalled");

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_key_waiting |-> out_key_out == '0)
    else $error("key_out nonzero without a waiting key");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_enqueued && out_dropped)
      && !(out_key_waiting && (out_enqueued || out_dropped)))
    else $error("check and sample results mixed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_valid |-> !out_ready)
    else $error("input stalled while the result word drains");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind key_press_edge_fifo_unit kpef_checker u_kpef_checker (.*);
